[hdl/gbfs_pkg.sv]
// Shared constants, types and step table for the grid shortest-path search core.
package gbfs_pkg;

  localparam int MAX_N   = 32;
  localparam int CELLS   = MAX_N * MAX_N;
  localparam int COORD_W = $clog2(MAX_N);
  localparam int IDX_W   = $clog2(CELLS);
  localparam int SIZE_W  = 6;
  localparam int LEN_W   = 11;
  localparam int POS_W   = IDX_W + 1;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
  localparam logic [POS_W-1:0] CELLS_POS = POS_W'(CELLS);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_N);

  // Step direction codes: two-bit two's complement, -1, 0 or +1
  localparam logic [1:0] STEP_ZERO = 2'b00;
  localparam logic [1:0] STEP_PLUS = 2'b01;
  localparam logic [1:0] STEP_MINUS = 2'b11;

  // One frontier queue entry: a cell by row and column
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } coord_t;

  // Row offset of each of the eight moves
  function automatic logic [1:0] step_row(input logic [2:0] d);
    logic [1:0] s;
    case (d)
      3'd0: s = STEP_ZERO;
      3'd1: s = STEP_PLUS;
      3'd2: s = STEP_ZERO;
      3'd3: s = STEP_MINUS;
      3'd4: s = STEP_MINUS;
      3'd5: s = STEP_PLUS;
      3'd6: s = STEP_PLUS;
      default: s = STEP_MINUS;
    endcase
    return s;
  endfunction

  // Column offset of each of the eight moves
  function automatic logic [1:0] step_col(input logic [2:0] d);
    logic [1:0] s;
    case (d)
      3'd0: s = STEP_PLUS;
      3'd1: s = STEP_ZERO;
      3'd2: s = STEP_MINUS;
      3'd3: s = STEP_ZERO;
      3'd4: s = STEP_PLUS;
      3'd5: s = STEP_PLUS;
      3'd6: s = STEP_MINUS;
      default: s = STEP_MINUS;
    endcase
    return s;
  endfunction

endpackage

[hdl/gbfs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module gbfs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hdl/grid_bfs_shortest_path_core.sv]
// Grid shortest-path core: loads a square grid, then runs an 8-connected BFS.
//
// Input channel (in_valid / in_stall): one word per grid cell in row-major
// order, carrying cell_blocked and last_cell. Cells past the n*n-th are
// dropped. The word with last_cell set is stored and then starts the search;
// in_stall stays high until the search is done.
// Output channel (out_valid / out_stall): one word per search, carrying found
// and path_length (cells on the shortest path, 0 when there is none).
// Search steps: a clear of the first n*32 visited-map entries, a check of the
// end cells (S_START0 to S_START2), then for each cell taken off the frontier
// queue a queue read, eight neighbor probes through the shared address unit
// and a drain step, and last a step to post the result. The neighbor probe path
// (one small multiply and add into the cell store address) is reused for all
// eight moves. A finished result sits in the output register; while the
// receiver stalls it, the core keeps loading the next grid and only holds a
// second result until the first one is taken.
// grid_size is written through cfg_we / cfg_wdata, by the user only while
// idle (not enforced by the core); 0 acts as 1 and values above 32 as 32.
// Synchronous reset: grid_size 32, output register empty, loader at cell 0.
module grid_bfs_shortest_path_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [gbfs_pkg::SIZE_W-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          cell_blocked,
  input  logic                          last_cell,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          found,
  output logic [gbfs_pkg::LEN_W-1:0]    path_length
);

  localparam logic [3:0] S_LOAD   = 4'd0;
  localparam logic [3:0] S_CLEAR  = 4'd1;
  localparam logic [3:0] S_START0 = 4'd2;
  localparam logic [3:0] S_START1 = 4'd3;
  localparam logic [3:0] S_START2 = 4'd4;
  localparam logic [3:0] S_POP    = 4'd5;
  localparam logic [3:0] S_CELL   = 4'd6;
  localparam logic [3:0] S_NBR    = 4'd7;
  localparam logic [3:0] S_DRAIN  = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  localparam int CW = gbfs_pkg::COORD_W;
  localparam int IW = gbfs_pkg::IDX_W;
  localparam int PW = gbfs_pkg::POS_W;
  localparam int SW = gbfs_pkg::SIZE_W;
  localparam int LW = gbfs_pkg::LEN_W;

  logic [3:0]    state;
  logic [SW-1:0] grid_size;
  logic [PW-1:0] load_pos;
  logic [IW-1:0] clr_addr;
  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic [PW-1:0] level_end;
  logic [LW-1:0] level;
  logic [CW-1:0] cur_r;
  logic [CW-1:0] cur_c;
  logic [2:0]    dir;
  logic          chk_valid;
  logic [CW-1:0] chk_r;
  logic [CW-1:0] chk_c;
  logic          blk0;
  logic          res_found;
  logic [LW-1:0] res_len;

  logic [SW-1:0]      n;
  logic [SW-1:0]      n_m1;
  logic [2*SW-1:0]    total_full;
  logic [PW-1:0]      total;
  logic [IW-1:0]      goal_lin;
  logic               in_acc;
  logic [1:0]         step_r;
  logic [1:0]         step_c;
  logic [SW-1:0]      rr;
  logic [SW-1:0]      cc;
  logic               inb;
  logic [CW-1:0]      nr;
  logic [CW-1:0]      nc;
  logic [CW+SW-1:0]   nbr_prod;
  logic [IW-1:0]      nbr_lin;
  logic               chk_take;
  gbfs_pkg::coord_t   q_head;
  gbfs_pkg::coord_t   q_wdata;

  logic          cell_we;
  logic [IW-1:0] cell_raddr;
  logic          cell_rdata;
  logic          vis_we;
  logic [IW-1:0] vis_waddr;
  logic          vis_wdata;
  logic          vis_rdata;
  logic          q_we;
  logic [IW-1:0] q_waddr;

  // Effective side length and grid size
  always_comb begin
    if (grid_size == '0) begin
      n = SW'(1);
    end else if (grid_size > SW'(gbfs_pkg::MAX_N)) begin
      n = SW'(gbfs_pkg::MAX_N);
    end else begin
      n = grid_size;
    end
    n_m1       = n - SW'(1);
    total_full = n * n;
    total      = total_full[PW-1:0];
    goal_lin   = IW'(total - PW'(1));
  end

  assign in_stall = (state != S_LOAD);
  assign in_acc   = in_valid && !in_stall;

  // Shared neighbor address unit: step, bound check, linear cell index
  always_comb begin
    step_r   = gbfs_pkg::step_row(dir);
    step_c   = gbfs_pkg::step_col(dir);
    rr       = {1'b0, cur_r} + {{(SW-2){step_r[1]}}, step_r};
    cc       = {1'b0, cur_c} + {{(SW-2){step_c[1]}}, step_c};
    inb      = (rr < n) && (cc < n);
    nr       = rr[CW-1:0];
    nc       = cc[CW-1:0];
    nbr_prod = nr * n;
    nbr_lin  = IW'(nbr_prod + (CW+SW)'(nc));
  end

  // Enqueue a probed neighbor that is open and not yet seen
  assign chk_take = chk_valid && !cell_rdata && !vis_rdata && (tail < gbfs_pkg::CELLS_POS);

  // Cell store ports
  always_comb begin
    cell_we = in_acc && (load_pos < total);
    case (state)
      S_START0: cell_raddr = '0;
      S_START1: cell_raddr = goal_lin;
      default:  cell_raddr = nbr_lin;
    endcase
  end

  // Visited map ports
  always_comb begin
    vis_we    = 1'b0;
    vis_waddr = {chk_r, chk_c};
    vis_wdata = 1'b1;
    if (state == S_CLEAR) begin
      vis_we    = 1'b1;
      vis_waddr = clr_addr;
      vis_wdata = 1'b0;
    end else if (state == S_START2) begin
      vis_we    = !blk0 && !cell_rdata;
      vis_waddr = '0;
    end else if (chk_take) begin
      vis_we = 1'b1;
    end
  end

  // Frontier queue ports
  always_comb begin
    q_we    = chk_take;
    q_waddr = tail[IW-1:0];
    q_wdata = '{row: chk_r, col: chk_c};
    if (state == S_START2) begin
      q_we    = !blk0 && !cell_rdata;
      q_waddr = '0;
      q_wdata = '0;
    end
  end

  gbfs_ram #(.WIDTH(1), .DEPTH(gbfs_pkg::CELLS)) u_cell (
    .clk   (clk),
    .we    (cell_we),
    .waddr (load_pos[IW-1:0]),
    .wdata (cell_blocked),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  gbfs_ram #(.WIDTH(1), .DEPTH(gbfs_pkg::CELLS)) u_visited (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_waddr),
    .wdata (vis_wdata),
    .raddr ({nr, nc}),
    .rdata (vis_rdata)
  );

  gbfs_ram #(.WIDTH(2*CW), .DEPTH(gbfs_pkg::CELLS)) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (head[IW-1:0]),
    .rdata (q_head)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= gbfs_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      grid_size <= cfg_wdata;
    end
  end

  // Probe pipeline stage: one neighbor in flight behind the address unit
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_valid <= 1'b0;
    end else begin
      chk_valid <= (state == S_NBR) && inb;
    end
    chk_r <= nr;
    chk_c <= nc;
  end

  // Sequencer: load, clear, seed, then pop and probe until goal or empty queue
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      load_pos <= '0;
      head     <= '0;
      tail     <= '0;
      level    <= '0;
    end else begin
      if (chk_take) begin
        tail <= tail + PW'(1);
      end
      case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (load_pos < total) begin
              load_pos <= load_pos + PW'(1);
            end else begin
              load_pos <= total;
            end
            if (last_cell) begin
              load_pos <= '0;
              clr_addr <= '0;
              state    <= S_CLEAR;
            end
          end
        end
        S_CLEAR: begin
          if (clr_addr == {n_m1[CW-1:0], {CW{1'b1}}}) begin
            state <= S_START0;
          end else begin
            clr_addr <= clr_addr + IW'(1);
          end
        end
        S_START0: begin
          state <= S_START1;
        end
        S_START1: begin
          blk0  <= cell_rdata;
          state <= S_START2;
        end
        S_START2: begin
          if (blk0 || cell_rdata) begin
            res_found <= 1'b0;
            res_len   <= '0;
            state     <= S_DONE;
          end else begin
            head      <= '0;
            tail      <= PW'(1);
            level     <= LW'(1);
            level_end <= PW'(1);
            state     <= S_POP;
          end
        end
        S_POP: begin
          if (head == tail) begin
            res_found <= 1'b0;
            res_len   <= '0;
            state     <= S_DONE;
          end else begin
            if (head == level_end) begin
              level     <= (level == gbfs_pkg::LEN_MAX) ? level : level + LW'(1);
              level_end <= tail;
            end
            head  <= head + PW'(1);
            state <= S_CELL;
          end
        end
        S_CELL: begin
          if ({1'b0, q_head.row} == n_m1 && {1'b0, q_head.col} == n_m1) begin
            res_found <= 1'b1;
            res_len   <= level;
            state     <= S_DONE;
          end else begin
            cur_r <= q_head.row;
            cur_c <= q_head.col;
            dir   <= '0;
            state <= S_NBR;
          end
        end
        S_NBR: begin
          dir <= dir + 3'd1;
          if (dir == 3'd7) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_POP;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            state <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // Output register: post a result once the previous word has left
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || !out_stall)) begin
      out_valid   <= 1'b1;
      found       <= res_found;
      path_length <= res_len;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[hdl/gbfs_checker.sv]
// Port-level checks for the grid shortest-path core, bound to the top level.
module gbfs_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        cfg_we,
  input logic [gbfs_pkg::SIZE_W-1:0] cfg_wdata,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        cell_blocked,
  input logic                        last_cell,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        found,
  input logic [gbfs_pkg::LEN_W-1:0]  path_length
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(found) && $stable(path_length))
    else $error("stalled result word changed");

  // A path is reported exactly when its length is nonzero
  a_found_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (found == (path_length != '0)))
    else $error("found and path_length disagree");

  // A path never holds more cells than the largest grid
  a_len_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (path_length <= gbfs_pkg::LEN_W'(gbfs_pkg::CELLS)))
    else $error("path_length beyond grid capacity");

  // The final cell word starts a search, so the input stalls right after it
  a_last_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_cell |=> in_stall)
    else $error("input not stalled after final cell");

  // A new result only appears while the input is stalled for the search
  a_result_in_search: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared outside a search");

endmodule

bind grid_bfs_shortest_path_core gbfs_checker u_gbfs_checker (.*);

[tb/grid_bfs_shortest_path_core_tb.sv]
// Self-checking testbench for the grid shortest-path search core.
module grid_bfs_shortest_path_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 100000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int LONG_HOLD      = 600;
  localparam int ITEM_TARGET    = 1600;
  localparam int PHASE2_MARGIN  = 200;

  typedef struct packed {
    logic blocked;
    logic last;
  } cell_word_t;

  typedef struct packed {
    logic                       found;
    logic [gbfs_pkg::LEN_W-1:0] len;
  } route_t;

  logic                        clk;
  logic                        rst          = 1'b1;
  logic                        cfg_we       = 1'b0;
  logic [gbfs_pkg::SIZE_W-1:0] cfg_wdata    = '0;
  logic                        in_valid     = 1'b0;
  logic                        in_stall;
  logic                        cell_blocked = 1'b0;
  logic                        last_cell    = 1'b0;
  logic                        out_valid;
  logic                        out_stall    = 1'b0;
  logic                        found;
  logic [gbfs_pkg::LEN_W-1:0]  path_length;

  // Words waiting to be sent and routes waiting to come back
  cell_word_t cell_words[$];
  route_t     expected_routes[$];
  route_t     head_route;

  // Predictor state: size register copy, stored grid, search scratch
  logic [gbfs_pkg::SIZE_W-1:0] size_reg = gbfs_pkg::SIZE_RESET;
  bit                          grid_cells[gbfs_pkg::CELLS];
  bit                          seen_map[gbfs_pkg::CELLS];
  int                          frontier[gbfs_pkg::CELLS];
  int                          load_pos = 0;

  // Generator-side view of the load position and of the written prefix
  int gen_pos  = 0;
  int gen_high = 0;

  int  errors        = 0;
  int  items_queued  = 0;
  int  grids_queued  = 0;
  int  paths_found   = 0;
  int  quiet_cycles  = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_count    = 0;
  bit  hold_armed    = 1'b0;
  bit  hold_done     = 1'b0;
  logic word_taken   = 1'b0;

  grid_bfs_shortest_path_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cell_blocked (cell_blocked),
    .last_cell    (last_cell),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found        (found),
    .path_length  (path_length)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Side in use: zero acts as one, oversize saturates
  function automatic int grid_side(logic [gbfs_pkg::SIZE_W-1:0] v);
    if (v == 0) return 1;
    if (v > gbfs_pkg::MAX_N) return gbfs_pkg::MAX_N;
    return int'(v);
  endfunction

  // Level-by-level 8-connected search from the top-left to the bottom-right cell
  function automatic int shortest_route(int n);
    int goal, head, tail, level, level_end, u, nr, nc, k;
    goal = (n - 1) * n + (n - 1);
    for (int i = 0; i < gbfs_pkg::CELLS; i++) seen_map[i] = 1'b0;
    if (grid_cells[0] || grid_cells[goal]) return 0;
    head = 0;
    tail = 1;
    frontier[0] = 0;
    seen_map[0] = 1'b1;
    level = 1;
    while (head < tail) begin
      level_end = tail;
      while (head < level_end) begin
        u = frontier[head];
        head++;
        if (u == goal) return level;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            nr = u / n + dr;
            nc = u % n + dc;
            if ((dr != 0 || dc != 0) && nr >= 0 && nc >= 0 && nr < n && nc < n) begin
              k = nr * n + nc;
              if (!grid_cells[k] && !seen_map[k] && tail < gbfs_pkg::CELLS) begin
                seen_map[k] = 1'b1;
                frontier[tail] = k;
                tail++;
              end
            end
          end
        end
      end
      level++;
    end
    return 0;
  endfunction

  // Store one accepted word; a last cell runs the search and queues its route
  task automatic take_cell(logic blocked, logic last);
    int n, total, len;
    route_t r;
    n = grid_side(size_reg);
    total = n * n;
    if (load_pos < total) begin
      grid_cells[load_pos] = blocked;
      load_pos++;
    end else begin
      load_pos = total;
    end
    if (last) begin
      load_pos = 0;
      len = shortest_route(n);
      if (len > int'(gbfs_pkg::LEN_MAX)) len = int'(gbfs_pkg::LEN_MAX);
      r.found = (len != 0);
      r.len = len[gbfs_pkg::LEN_W-1:0];
      expected_routes = {expected_routes, r};
    end
  endtask

  // Queue one word and track which positions it will have written
  task automatic queue_cell(bit blocked, bit last);
    int total;
    cell_word_t w;
    total = grid_side(size_reg) * grid_side(size_reg);
    if (gen_pos < total) begin
      gen_pos++;
      if (gen_pos > gen_high) gen_high = gen_pos;
    end else begin
      gen_pos = total;
    end
    if (last) gen_pos = 0;
    w.blocked = blocked;
    w.last = last;
    cell_words = {cell_words, w};
    items_queued++;
  endtask

  // Queue one grid: full, overrun past the end, or ended early over old content
  task automatic queue_grid(int kind);
    int n, total, pct, count, short_max;
    bit blk;
    n = grid_side(size_reg);
    total = n * n;
    pct = $urandom_range(0, 45);
    count = total;
    if (kind == 1) begin
      count = total + $urandom_range(1, 4);
    end else if (kind == 2 && gen_high >= total && total > 1) begin
      short_max = (total - 1 < 24) ? total - 1 : 24;
      count = $urandom_range(1, short_max);
    end
    for (int i = 0; i < count; i++) begin
      blk = ($urandom_range(0, 99) < pct);
      // keep the end cells mostly open so paths do turn up
      if ((i == 0 || i == total - 1) && $urandom_range(0, 7) != 0) blk = 1'b0;
      queue_cell(blk, i == count - 1);
    end
    grids_queued++;
  endtask

  // Write the size register between phases
  task automatic write_size(logic [gbfs_pkg::SIZE_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    size_reg = v;
  endtask

  // Wait until every word is sent and every route has come back, then settle
  task automatic wait_quiet();
    do @(negedge clk);
    while (cell_words.size() != 0 || in_valid || expected_routes.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Accept input words and run the predictor on them
  always @(posedge clk) begin
    word_taken <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      cell_words.delete(0);
      take_cell(cell_blocked, last_cell);
    end
  end

  // Drive the input channel: hold a stalled word, else offer the next one or idle
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !word_taken) begin
      // hold the stalled word
    end else if (cell_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
      in_valid <= 1'b1;
      cell_blocked <= cell_words[0].blocked;
      last_cell <= cell_words[0].last;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Drive the output stall: one long hold when armed, random stalls otherwise
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_armed && !hold_done) begin
      out_stall <= 1'b1;
      hold_count++;
      if (hold_count >= LONG_HOLD) hold_done = 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Check each result word against the oldest expected route
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_routes.size() == 0) begin
        $display("%0t: unexpected result word found=%0d path_length=%0d",
                 $time, found, path_length);
        errors++;
      end else begin
        head_route = expected_routes.pop_front();
        if (found !== head_route.found) begin
          $display("%0t: found mismatch: expected %0d, actual %0d",
                   $time, head_route.found, found);
          errors++;
        end
        if (path_length !== head_route.len) begin
          $display("%0t: path_length mismatch: expected %0d, actual %0d",
                   $time, head_route.len, path_length);
          errors++;
        end
        if (head_route.found) paths_found++;
      end
    end
  end

  // Stop the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, %0d words and %0d routes still pending",
               $time, cell_words.size(), expected_routes.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int phase, pick, n_grids, budget;
    logic [gbfs_pkg::SIZE_W-1:0] size_val;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Single cell grids: open, blocked
    write_size(6'd1);
    @(posedge clk);
    queue_cell(1'b0, 1'b1);
    queue_cell(1'b1, 1'b1);
    grids_queued += 2;
    wait_quiet();

    // Size zero acts as one; extra cells past the end are dropped
    write_size(6'd0);
    @(posedge clk);
    queue_cell(1'b0, 1'b0);
    queue_cell(1'b0, 1'b0);
    queue_cell(1'b1, 1'b1);
    grids_queued++;
    wait_quiet();

    // 2x2: diagonal path, blocked start, early end over old content, blocked goal
    write_size(6'd2);
    @(posedge clk);
    queue_cell(1'b0, 1'b0); queue_cell(1'b1, 1'b0);
    queue_cell(1'b1, 1'b0); queue_cell(1'b0, 1'b1);
    queue_cell(1'b1, 1'b0); queue_cell(1'b0, 1'b0);
    queue_cell(1'b0, 1'b0); queue_cell(1'b0, 1'b1);
    queue_cell(1'b0, 1'b1);
    queue_cell(1'b0, 1'b0); queue_cell(1'b0, 1'b0);
    queue_cell(1'b0, 1'b0); queue_cell(1'b1, 1'b1);
    grids_queued += 4;
    wait_quiet();

    // 3x3 with a full blocked middle column: no path
    write_size(6'd3);
    @(posedge clk);
    for (int i = 0; i < 9; i++) queue_cell(i % 3 == 1, i == 8);
    grids_queued++;

    // Random phases over sizes and idling patterns
    phase = 0;
    while (phase < 4 || items_queued < ITEM_TARGET) begin
      wait_quiet();
      case (phase)
        0: size_val = 6'd63;
        1: size_val = 6'd33;
        3: size_val = 6'd2;
        default: begin
          pick = $urandom_range(0, 11);
          size_val = (pick == 10) ? 6'd12 : (pick == 11) ? 6'd16 :
                     pick[gbfs_pkg::SIZE_W-1:0];
        end
      endcase
      write_size(size_val);
      @(posedge clk);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      if (phase == 3) begin
        // long output hold while the sender keeps offering
        send_idle_pct = 0;
        hold_armed = 1'b1;
      end
      if (phase == 0) begin
        queue_grid(0);
        repeat (3) queue_grid(2);
      end else if (phase == 1) begin
        repeat (4) queue_grid(2);
      end else begin
        n_grids = (phase == 3) ? 40 : $urandom_range(8, 14);
        budget = (phase == 2) ? ITEM_TARGET - PHASE2_MARGIN : ITEM_TARGET;
        repeat (n_grids) begin
          // stay near the item count outside the long-hold phase
          if (phase != 3 && items_queued >= budget) break;
          pick = $urandom_range(0, 9);
          if (pick < 7) begin
            queue_grid(0);
          end else if (pick == 7) begin
            queue_grid(1);
          end else if (pick == 8) begin
            queue_grid(2);
          end else begin
            // stray cells with no last flag shift the load position
            repeat ($urandom_range(1, 3)) queue_cell($urandom_range(0, 1), 1'b0);
            queue_grid(0);
          end
        end
      end
      phase++;
    end

    wait_quiet();
    $display("Ran %0d cell words in %0d grids over sizes 1 to 32, %0d paths found.",
             items_queued, grids_queued, paths_found);
    $display("Idling covered none, input gaps, output stalls, both, and one long hold.");
    if (errors == 0 && expected_routes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
